>>> hdl/dra_pkg.sv
// Shared types and constants for the delayed-reuse slot allocator.
package dra_pkg;

  // Fixed field widths
  localparam int SLOT_W    = 10;
  localparam int TIME_W    = 32;
  localparam int CS_W      = 7;
  localparam int DELAY_W   = 16;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  // Action codes
  localparam logic ACTION_ALLOC = 1'b0;
  localparam logic ACTION_FREE  = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CLIENT_SLOTS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRACE_TIME   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_REUSE_DELAY  = 2'd2;

  // Configuration reset values
  localparam logic [CS_W-1:0]    CLIENT_SLOTS_RST = 7'd1;
  localparam logic [DELAY_W-1:0] GRACE_TIME_RST   = 16'd2000;
  localparam logic [DELAY_W-1:0] REUSE_DELAY_RST  = 16'd500;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_FULL     = 2'd1,
    STATUS_BAD_SLOT = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_RESP
  } back_state_t;

  // Configuration registers as seen by the back end
  typedef struct packed {
    logic [CS_W-1:0]    client_slots;
    logic [DELAY_W-1:0] grace_time_ms;
    logic [DELAY_W-1:0] reuse_delay_ms;
  } cfg_t;

  // Classified request between front and back
  typedef struct packed {
    logic              is_free;
    logic [SLOT_W-1:0] slot_index;
    logic [TIME_W-1:0] now_ms;
  } req_t;

  // Result item
  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    status_t           status;
    logic              reused;
  } res_t;

  // One slot table entry
  typedef struct packed {
    logic              free;
    logic [TIME_W-1:0] stamp;
  } slot_entry_t;

endpackage

>>> hdl/dra_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/dra_fifo.sv
// Small register FIFO used for the request and result queues (DEPTH >= 2).
module dra_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  // Pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> hdl/dra_front.sv
// Front end: takes requests, decodes the action and queues them for the back end.
module dra_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       hold,
  input  logic                       push,
  input  logic                       action,
  input  logic [dra_pkg::SLOT_W-1:0] slot_index,
  input  logic [dra_pkg::TIME_W-1:0] now_ms,
  output logic                       full,
  output logic                       req_valid,
  output dra_pkg::req_t              req,
  input  logic                       req_pop
);

  dra_pkg::req_t                   req_in;
  logic [$bits(dra_pkg::req_t)-1:0] q_rdata;
  logic                            q_full;
  logic                            q_empty;

  // Classify the incoming request
  always_comb begin
    req_in.is_free    = (action == dra_pkg::ACTION_FREE);
    req_in.slot_index = slot_index;
    req_in.now_ms     = now_ms;
  end

  // No request is taken while the table is being cleared
  assign full = q_full || hold;

  dra_fifo #(
    .WIDTH($bits(dra_pkg::req_t)),
    .DEPTH(2)
  ) u_req_q (
    .clk  (clk),
    .rst  (rst),
    .push (push && !hold),
    .wdata(req_in),
    .full (q_full),
    .pop  (req_pop),
    .rdata(q_rdata),
    .empty(q_empty)
  );

  assign req_valid = !q_empty;
  assign req       = dra_pkg::req_t'(q_rdata);

endmodule

>>> hdl/dra_back.sv
// Back end: slot table, high-water count and the allocate scan sequencer.
module dra_back #(
  parameter int MAX_SLOTS = 1024
) (
  input  logic          clk,
  input  logic          rst,
  input  dra_pkg::cfg_t cfg,
  output logic          clearing,
  input  logic          req_valid,
  input  dra_pkg::req_t req,
  output logic          req_pop,
  output logic          res_push,
  output dra_pkg::res_t res,
  input  logic          res_full
);

  localparam int AW    = $clog2(MAX_SLOTS);
  localparam int CNT_W = $clog2(MAX_SLOTS + 1);
  localparam int LO_W  = dra_pkg::CS_W + 1;
  localparam int CW0   = (CNT_W > LO_W) ? CNT_W : LO_W;
  localparam int CMP_W = (CW0 > dra_pkg::SLOT_W) ? CW0 : dra_pkg::SLOT_W;
  localparam int EW    = $bits(dra_pkg::slot_entry_t);

  dra_pkg::back_state_t state, state_next;

  logic [AW-1:0]         clr_ptr, clr_ptr_next;
  logic [CNT_W-1:0]      high_water, high_water_next;
  logic [CNT_W-1:0]      scan_ptr, scan_ptr_next;
  logic                  pend_valid, pend_valid_next;
  logic [AW-1:0]         pend_idx, pend_idx_next;
  dra_pkg::req_t         cur, cur_next;
  dra_pkg::res_t         res_next;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  dra_pkg::slot_entry_t  ram_wdata;
  logic                  ram_re;
  logic [AW-1:0]         ram_raddr;
  logic [EW-1:0]         ram_rdata;
  dra_pkg::slot_entry_t  entry;

  logic [CMP_W-1:0]      lo_ext, hw_ext, max_ext, count_ext, start_ext, idx_ext;
  logic [CMP_W-1:0]      grow_ext, scan_ext, pend_ext;
  logic [dra_pkg::TIME_W-1:0] elapsed;
  logic                  issue;
  logic                  hit;

  // Effective count: max(high_water, client_slots+1), capped at MAX_SLOTS
  always_comb begin
    lo_ext    = CMP_W'(cfg.client_slots) + CMP_W'(1);
    hw_ext    = CMP_W'(high_water);
    max_ext   = CMP_W'(MAX_SLOTS);
    count_ext = (hw_ext > lo_ext) ? hw_ext : lo_ext;
    if (count_ext > max_ext) begin
      count_ext = max_ext;
    end
    start_ext = (lo_ext < count_ext) ? lo_ext : count_ext;
    grow_ext  = count_ext + CMP_W'(1);
    idx_ext   = CMP_W'(req.slot_index);
    scan_ext  = CMP_W'(scan_ptr);
    pend_ext  = CMP_W'(pend_idx);
  end

  // Reuse test on the entry read back for the pending scan slot
  assign entry   = dra_pkg::slot_entry_t'(ram_rdata);
  assign elapsed = cur.now_ms - entry.stamp;
  assign issue   = (scan_ext < count_ext);
  assign hit     = pend_valid && entry.free &&
                   ((entry.stamp < dra_pkg::TIME_W'(cfg.grace_time_ms)) ||
                    ((cur.now_ms >= entry.stamp) &&
                     (elapsed > dra_pkg::TIME_W'(cfg.reuse_delay_ms))));

  assign clearing = (state == dra_pkg::ST_CLEAR);

  // Slot table: free flag and stamp per slot
  dra_ram #(
    .WIDTH(EW),
    .DEPTH(MAX_SLOTS)
  ) u_slot_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // State and control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= dra_pkg::ST_CLEAR;
      clr_ptr    <= '0;
      high_water <= '0;
      pend_valid <= 1'b0;
    end else begin
      state      <= state_next;
      clr_ptr    <= clr_ptr_next;
      high_water <= high_water_next;
      pend_valid <= pend_valid_next;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    scan_ptr <= scan_ptr_next;
    pend_idx <= pend_idx_next;
    cur      <= cur_next;
    res      <= res_next;
  end

  // Next state and outputs
  always_comb begin
    state_next      = state;
    clr_ptr_next    = clr_ptr;
    high_water_next = high_water;
    scan_ptr_next   = scan_ptr;
    pend_valid_next = pend_valid;
    pend_idx_next   = pend_idx;
    cur_next        = cur;
    res_next        = res;
    ram_we          = 1'b0;
    ram_waddr       = clr_ptr;
    ram_wdata       = '0;
    ram_re          = 1'b0;
    ram_raddr       = scan_ptr[AW-1:0];
    req_pop         = 1'b0;
    res_push        = 1'b0;

    case (state)
      // Clearing pass: one entry per cycle after reset
      dra_pkg::ST_CLEAR: begin
        ram_we       = 1'b1;
        clr_ptr_next = clr_ptr + 1'b1;
        if (clr_ptr == AW'(MAX_SLOTS - 1)) begin
          state_next = dra_pkg::ST_IDLE;
        end
      end

      // Take a request; free is done at once, allocate starts the scan
      dra_pkg::ST_IDLE: begin
        if (req_valid) begin
          req_pop  = 1'b1;
          cur_next = req;
          if (req.is_free) begin
            res_next.slot   = req.slot_index;
            res_next.reused = 1'b0;
            if (idx_ext >= count_ext) begin
              res_next.status = dra_pkg::STATUS_BAD_SLOT;
            end else begin
              res_next.status = dra_pkg::STATUS_OK;
              ram_we          = 1'b1;
              ram_waddr       = idx_ext[AW-1:0];
              ram_wdata.free  = 1'b1;
              ram_wdata.stamp = req.now_ms;
            end
            state_next = dra_pkg::ST_RESP;
          end else begin
            scan_ptr_next   = start_ext[CNT_W-1:0];
            pend_valid_next = 1'b0;
            state_next      = dra_pkg::ST_SCAN;
          end
        end
      end

      // Scan: one read issued and one entry checked per cycle
      dra_pkg::ST_SCAN: begin
        ram_re          = issue;
        pend_valid_next = issue;
        pend_idx_next   = scan_ptr[AW-1:0];
        if (issue) begin
          scan_ptr_next = scan_ptr + 1'b1;
        end
        if (hit) begin
          ram_we          = 1'b1;
          ram_waddr       = pend_idx;
          res_next.slot   = pend_ext[dra_pkg::SLOT_W-1:0];
          res_next.status = dra_pkg::STATUS_OK;
          res_next.reused = 1'b1;
          pend_valid_next = 1'b0;
          state_next      = dra_pkg::ST_RESP;
        end else if (!issue && !pend_valid) begin
          res_next.reused = 1'b0;
          if (count_ext == max_ext) begin
            res_next.slot   = '0;
            res_next.status = dra_pkg::STATUS_FULL;
          end else begin
            ram_we          = 1'b1;
            ram_waddr       = count_ext[AW-1:0];
            high_water_next = grow_ext[CNT_W-1:0];
            res_next.slot   = count_ext[dra_pkg::SLOT_W-1:0];
            res_next.status = dra_pkg::STATUS_OK;
          end
          pend_valid_next = 1'b0;
          state_next      = dra_pkg::ST_RESP;
        end
      end

      // Hand the result to the result queue
      dra_pkg::ST_RESP: begin
        if (!res_full) begin
          res_push   = 1'b1;
          state_next = dra_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = dra_pkg::ST_IDLE;
      end
    endcase
  end

  // High-water count only grows between resets
  a_hw_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (high_water >= $past(high_water)))
    else $error("high_water decreased");

  // High-water count stays within the table
  a_hw_bound: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (CMP_W'(high_water) <= CMP_W'(MAX_SLOTS)))
    else $error("high_water beyond table");

  // A reused slot is marked taken in the same cycle
  a_hit_write: assert property (@(posedge clk) disable iff (rst)
    (state == dra_pkg::ST_SCAN && hit) |-> (ram_we && !ram_wdata.free && ram_waddr == pend_idx))
    else $error("reused slot not marked taken");

  // A blocked result is held unchanged
  a_resp_hold: assert property (@(posedge clk) disable iff (rst)
    (state == dra_pkg::ST_RESP && res_full) |=> (state == dra_pkg::ST_RESP && $stable(res)))
    else $error("result lost while result queue full");

  // No request is taken during the clearing pass
  a_clear_no_pop: assert property (@(posedge clk) disable iff (rst)
    (state == dra_pkg::ST_CLEAR) |-> (!req_pop && !res_push))
    else $error("request handled during clearing pass");

endmodule

>>> hdl/delayed_reuse_slot_allocator.sv
// Top level of the delayed-reuse slot allocator: config registers, front, back, result queue.
//
//  channel   | handshake             | payload
//  ----------+-----------------------+-----------------------------------
//  request   | push / full           | action, slot_index, now_ms
//  result    | empty / pop           | slot, status, reused
//  config    | cfg_we (no wait)      | cfg_index, cfg_data
//
// After reset the slot table is cleared entry by entry; full stays high meanwhile.
// A free inside the effective count is written to the slot table when taken; an allocate scans the slots from
// client_slots+1 up to the effective count (up to MAX_SLOTS), one at a time through
// the single read port of the slot table, and takes the next new slot, or reports
// full, when no scanned slot can be reused.
// Two-entry queues on both sides let requests and results stall independently.
module delayed_reuse_slot_allocator #(
  parameter int MAX_SLOTS = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic                          action,
  input  logic [dra_pkg::SLOT_W-1:0]    slot_index,
  input  logic [dra_pkg::TIME_W-1:0]    now_ms,
  output logic                          empty,
  input  logic                          pop,
  output logic [dra_pkg::SLOT_W-1:0]    slot,
  output logic [1:0]                    status,
  output logic                          reused,
  input  logic                          cfg_we,
  input  logic [dra_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dra_pkg::CFG_DAT_W-1:0] cfg_data
);

  dra_pkg::cfg_t                    cfg;
  logic                             clearing;
  logic                             req_valid;
  dra_pkg::req_t                    req;
  logic                             req_pop;
  logic                             res_push;
  dra_pkg::res_t                    res;
  logic                             res_full;
  logic [$bits(dra_pkg::res_t)-1:0] out_rdata;
  dra_pkg::res_t                    res_out;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.client_slots   <= dra_pkg::CLIENT_SLOTS_RST;
      cfg.grace_time_ms  <= dra_pkg::GRACE_TIME_RST;
      cfg.reuse_delay_ms <= dra_pkg::REUSE_DELAY_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        dra_pkg::CFG_CLIENT_SLOTS: cfg.client_slots   <= cfg_data[dra_pkg::CS_W-1:0];
        dra_pkg::CFG_GRACE_TIME:   cfg.grace_time_ms  <= cfg_data;
        dra_pkg::CFG_REUSE_DELAY:  cfg.reuse_delay_ms <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  dra_front u_front (
    .clk       (clk),
    .rst       (rst),
    .hold      (clearing),
    .push      (push),
    .action    (action),
    .slot_index(slot_index),
    .now_ms    (now_ms),
    .full      (full),
    .req_valid (req_valid),
    .req       (req),
    .req_pop   (req_pop)
  );

  dra_back #(
    .MAX_SLOTS(MAX_SLOTS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .clearing (clearing),
    .req_valid(req_valid),
    .req      (req),
    .req_pop  (req_pop),
    .res_push (res_push),
    .res      (res),
    .res_full (res_full)
  );

  // Result queue
  dra_fifo #(
    .WIDTH($bits(dra_pkg::res_t)),
    .DEPTH(2)
  ) u_res_q (
    .clk  (clk),
    .rst  (rst),
    .push (res_push),
    .wdata(res),
    .full (res_full),
    .pop  (pop),
    .rdata(out_rdata),
    .empty(empty)
  );

  assign res_out = dra_pkg::res_t'(out_rdata);
  assign slot    = res_out.slot;
  assign status  = res_out.status;
  assign reused  = res_out.reused;

endmodule

>>> test/tb_delayed_reuse_slot_allocator.sv
// Testbench for the delayed-reuse slot allocator: directed table, random traffic, full-table fill.
`timescale 1ns / 100ps

module tb_delayed_reuse_slot_allocator;

  localparam int MAX_SLOTS   = 1024;
  localparam int DIR_ROWS    = 23;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 90;
  localparam int HOLD_CYCLES = 2500;
  localparam int TAIL_CYCLES = 40;
  // Slowest gap between handshakes: clear pass plus a full-table scan,
  // a long receiver hold and idle bursts on top; taken several times over.
  localparam int STALL_LIMIT = 20000;

  // Directed stimulus row; res holds the expected result when fixed is set
  typedef struct packed {
    logic                       act;
    logic [dra_pkg::SLOT_W-1:0] idx;
    logic [dra_pkg::TIME_W-1:0] now;
    bit                         fixed;
    dra_pkg::res_t              res;
  } dir_row_t;

  logic                          clk = 1'b0;
  logic                          rst;
  logic                          push;
  logic                          full;
  logic                          action;
  logic [dra_pkg::SLOT_W-1:0]    slot_index;
  logic [dra_pkg::TIME_W-1:0]    now_ms;
  logic                          empty;
  logic                          pop;
  logic [dra_pkg::SLOT_W-1:0]    slot;
  logic [1:0]                    status;
  logic                          reused;
  logic                          cfg_we;
  logic [dra_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [dra_pkg::CFG_DAT_W-1:0] cfg_data;

  // Shadow copy of the slot table and the registers
  bit                          shadow_free  [MAX_SLOTS];
  bit [dra_pkg::TIME_W-1:0]    shadow_stamp [MAX_SLOTS];
  int unsigned                 shadow_hwm   = 0;
  logic [dra_pkg::CS_W-1:0]    shadow_cs    = dra_pkg::CLIENT_SLOTS_RST;
  logic [dra_pkg::DELAY_W-1:0] shadow_grace = dra_pkg::GRACE_TIME_RST;
  logic [dra_pkg::DELAY_W-1:0] shadow_delay = dra_pkg::REUSE_DELAY_RST;

  dra_pkg::res_t pending_results [$];
  dra_pkg::res_t popped_res;
  dra_pkg::res_t predicted_res;
  bit            fixed_valid  = 1'b0;
  dra_pkg::res_t fixed_res;
  bit            hold_off_req = 1'b0;
  bit            quiet        = 1'b0;
  int            err_cnt      = 0;
  int            stall_cycles = 0;
  logic [dra_pkg::TIME_W-1:0] t_ms;

  dir_row_t dir_tab [DIR_ROWS] = '{
    // reset settings: client_slots 1, grace 2000, delay 500
    '{dra_pkg::ACTION_ALLOC, 10'd0,   32'd0,   1'b1, '{10'd2,   dra_pkg::STATUS_OK,       1'b0}},
    '{dra_pkg::ACTION_ALLOC, 10'h3FF, 32'd0,   1'b1, '{10'd3,   dra_pkg::STATUS_OK,       1'b0}},
    '{dra_pkg::ACTION_FREE,  10'h3FF, 32'd0,   1'b1, '{10'h3FF, dra_pkg::STATUS_BAD_SLOT, 1'b0}},
    '{dra_pkg::ACTION_FREE,  10'd4,   32'd0,   1'b1, '{10'd4,   dra_pkg::STATUS_BAD_SLOT, 1'b0}},
    '{dra_pkg::ACTION_FREE,  10'd2,   32'd100, 1'b1, '{10'd2,   dra_pkg::STATUS_OK,       1'b0}},
    '{dra_pkg::ACTION_ALLOC, 10'd0,   32'd100, 1'b1, '{10'd2,   dra_pkg::STATUS_OK,       1'b1}},
    // quarantine boundary around reuse_delay
    '{dra_pkg::ACTION_FREE,  10'd3,    32'd3000,      1'b0, '0},
    '{dra_pkg::ACTION_ALLOC, 10'd0,    32'd3200,      1'b0, '0},
    '{dra_pkg::ACTION_ALLOC, 10'd0,    32'd3500,      1'b0, '0},
    '{dra_pkg::ACTION_ALLOC, 10'd0,    32'd3501,      1'b0, '0},
    // reserved slots may be freed but are never handed out
    '{dra_pkg::ACTION_FREE,  10'd0,    32'd5000,      1'b0, '0},
    '{dra_pkg::ACTION_FREE,  10'd1,    32'd5000,      1'b0, '0},
    '{dra_pkg::ACTION_ALLOC, 10'd0,    32'd6000,      1'b0, '0},
    // double free restamps; time going backward blocks reuse
    '{dra_pkg::ACTION_FREE,  10'd5,    32'd20000,     1'b0, '0},
    '{dra_pkg::ACTION_FREE,  10'd5,    32'd30000,     1'b0, '0},
    '{dra_pkg::ACTION_ALLOC, 10'd0,    32'd20600,     1'b0, '0},
    '{dra_pkg::ACTION_ALLOC, 10'd0,    32'd30501,     1'b0, '0},
    // time extremes
    '{dra_pkg::ACTION_FREE,  10'd4,    32'hFFFF_FFFF, 1'b0, '0},
    '{dra_pkg::ACTION_ALLOC, 10'd0,    32'hFFFF_FFFF, 1'b0, '0},
    '{dra_pkg::ACTION_FREE,  10'd6,    32'd0,         1'b0, '0},
    '{dra_pkg::ACTION_ALLOC, 10'd0,    32'd0,         1'b0, '0},
    '{dra_pkg::ACTION_ALLOC, 10'd0,    32'h8000_0000, 1'b0, '0},
    '{dra_pkg::ACTION_FREE,  10'h155,  32'hAAAA_5555, 1'b0, '0}
  };

  delayed_reuse_slot_allocator #(
    .MAX_SLOTS(MAX_SLOTS)
  ) u_top (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .action     (action),
    .slot_index (slot_index),
    .now_ms     (now_ms),
    .empty      (empty),
    .pop        (pop),
    .slot       (slot),
    .status     (status),
    .reused     (reused),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Count of slots in use: high-water mark, at least client_slots+1, capped at table size
  function automatic int unsigned live_count();
    int unsigned lo;
    int unsigned n;
    lo = shadow_cs + 1;
    n  = (shadow_hwm > lo) ? shadow_hwm : lo;
    return (n > MAX_SLOTS) ? MAX_SLOTS : n;
  endfunction

  // Predict the result of one request and update the shadow table
  function automatic dra_pkg::res_t predict_slot_result(
      input logic act, input logic [dra_pkg::SLOT_W-1:0] idx,
      input logic [dra_pkg::TIME_W-1:0] now);
    dra_pkg::res_t r;
    int unsigned   cnt;
    int unsigned   hit;
    bit            found;
    cnt      = live_count();
    r.slot   = '0;
    r.status = dra_pkg::STATUS_OK;
    r.reused = 1'b0;
    found    = 1'b0;
    hit      = 0;
    if (act == dra_pkg::ACTION_ALLOC) begin
      // first free slot stamped before the grace time or out of quarantine
      for (int unsigned k = shadow_cs + 1; k < cnt; k++) begin
        if (!found && shadow_free[k] &&
            (shadow_stamp[k] < shadow_grace ||
             (now >= shadow_stamp[k] && now - shadow_stamp[k] > shadow_delay))) begin
          found = 1'b1;
          hit   = k;
        end
      end
      if (found) begin
        shadow_free[hit] = 1'b0;
        r.slot   = hit[dra_pkg::SLOT_W-1:0];
        r.reused = 1'b1;
      end else if (cnt >= MAX_SLOTS) begin
        r.status = dra_pkg::STATUS_FULL;
      end else begin
        shadow_free[cnt] = 1'b0;
        r.slot     = cnt[dra_pkg::SLOT_W-1:0];
        shadow_hwm = cnt + 1;
      end
    end else begin
      r.slot = idx;
      if (idx >= cnt) begin
        r.status = dra_pkg::STATUS_BAD_SLOT;
      end else begin
        shadow_free[idx]  = 1'b1;
        shadow_stamp[idx] = now;
      end
    end
    return r;
  endfunction

  // Offer one request from a falling edge; returns at the falling edge after acceptance
  task automatic send_req(input logic act, input logic [dra_pkg::SLOT_W-1:0] idx,
                          input logic [dra_pkg::TIME_W-1:0] now);
    push       <= 1'b1;
    action     <= act;
    slot_index <= idx;
    now_ms     <= now;
    @(posedge clk);
    while (full) @(posedge clk);
    @(negedge clk);
  endtask

  // Random idle burst on the request side
  task automatic sender_gap();
    if (!quiet && $urandom_range(0, 5) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
  endtask

  // Stop requesting until every outstanding result has been popped
  task automatic drain_results();
    push <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // Write all three registers on consecutive cycles; block must be idle
  task automatic set_config(input logic [dra_pkg::CS_W-1:0] cs,
                            input logic [dra_pkg::DELAY_W-1:0] grace,
                            input logic [dra_pkg::DELAY_W-1:0] delay);
    cfg_we    <= 1'b1;
    cfg_index <= dra_pkg::CFG_CLIENT_SLOTS;
    cfg_data  <= {{(dra_pkg::CFG_DAT_W-dra_pkg::CS_W){1'b0}}, cs};
    @(negedge clk);
    cfg_index <= dra_pkg::CFG_GRACE_TIME;
    cfg_data  <= grace;
    @(negedge clk);
    cfg_index <= dra_pkg::CFG_REUSE_DELAY;
    cfg_data  <= delay;
    @(negedge clk);
    cfg_we       <= 1'b0;
    shadow_cs    = cs;
    shadow_grace = grace;
    shadow_delay = delay;
  endtask

  // Result check and request prediction at each rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (pop && !empty) begin
        if (pending_results.size() == 0) begin
          $error("result with no request pending: slot %0d status %0d reused %0d",
                 slot, status, reused);
          err_cnt++;
        end else begin
          popped_res = pending_results.pop_front();
          if (slot !== popped_res.slot) begin
            $error("slot: expected %0d, got %0d", popped_res.slot, slot);
            err_cnt++;
          end
          if (status !== popped_res.status) begin
            $error("status: expected %0d, got %0d", popped_res.status, status);
            err_cnt++;
          end
          if (reused !== popped_res.reused) begin
            $error("reused: expected %0d, got %0d", popped_res.reused, reused);
            err_cnt++;
          end
        end
      end
      if (push && !full) begin
        predicted_res = predict_slot_result(action, slot_index, now_ms);
        pending_results.push_back(fixed_valid ? fixed_res : predicted_res);
      end
    end
  end

  // Result side: random pop bursts and one long hold-off on request
  initial begin
    pop = 1'b0;
    wait (rst === 1'b0);
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        pop <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_off_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 11) == 0) begin
        pop <= 1'b0;
        repeat ($urandom_range(0, 15)) @(negedge clk);
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Watchdog: ends the run when no handshake happens for too long
  initial begin
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst && ((push && !full) || (pop && !empty))) stall_cycles = 0;
      else stall_cycles++;
    end
    $display("no handshake for %0d cycles", STALL_LIMIT);
    $display("status: fail");
    $finish;
  end

  // Request side: directed table, random phases, then fill the table to the top
  initial begin
    int                         n;
    int                         k;
    int unsigned                cnt;
    logic                       act;
    logic [dra_pkg::SLOT_W-1:0] idx;
    rst        = 1'b1;
    push       = 1'b0;
    action     = dra_pkg::ACTION_ALLOC;
    slot_index = '0;
    now_ms     = '0;
    cfg_we     = 1'b0;
    cfg_index  = dra_pkg::CFG_CLIENT_SLOTS;
    cfg_data   = '0;
    t_ms       = 32'd40000;
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    // table clear after reset holds full high
    do @(negedge clk); while (full !== 1'b0);

    // directed part under reset settings
    foreach (dir_tab[r]) begin
      fixed_valid = dir_tab[r].fixed;
      fixed_res   = dir_tab[r].res;
      send_req(dir_tab[r].act, dir_tab[r].idx, dir_tab[r].now);
      sender_gap();
    end
    fixed_valid = 1'b0;

    // random phases, each under its own register settings
    for (int ph = 0; ph < PHASES; ph++) begin
      drain_results();
      case (ph)
        0: set_config(7'd0, 16'd0, 16'd0);
        1: set_config(7'd64, 16'hFFFF, 16'hFFFF);
        2: set_config(7'd3, dra_pkg::DELAY_W'($urandom_range(0, 65535)),
                      dra_pkg::DELAY_W'($urandom_range(0, 65535)));
        3: set_config(dra_pkg::CS_W'($urandom_range(0, 8)), 16'd2000, 16'd500);
        4: set_config(7'd0, 16'hFFFF, 16'd0);
        default: set_config(dra_pkg::CS_W'($urandom_range(0, 64)), 16'd0,
                            dra_pkg::DELAY_W'($urandom_range(0, 65535)));
      endcase
      // result side stalls long while requests keep coming
      if (ph == 2) hold_off_req = 1'b1;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        cnt = live_count();
        // mostly forward time, with jumps, wraps and steps backward
        k = $urandom_range(0, 99);
        if (k < 3) t_ms = $urandom();
        else if (k < 6) t_ms = $urandom_range(0, 3000);
        else if (k < 10) t_ms = t_ms - $urandom_range(1, 600);
        else if (k < 22) t_ms = t_ms + $urandom_range(0, 80000);
        else t_ms = t_ms + $urandom_range(0, 400);
        idx = dra_pkg::SLOT_W'($urandom_range(0, MAX_SLOTS - 1));
        if ($urandom_range(0, 99) < ((cnt < 120) ? 50 : 30)) begin
          act = dra_pkg::ACTION_ALLOC;
        end else begin
          // free: mostly handed-out slots, some reserved and some past the count
          act = dra_pkg::ACTION_FREE;
          k   = $urandom_range(0, 99);
          if (k < 60 && shadow_cs + 1 < cnt) begin
            idx = dra_pkg::SLOT_W'($urandom_range(shadow_cs + 1, cnt - 1));
          end else if (k < 80) begin
            idx = dra_pkg::SLOT_W'($urandom_range(0, cnt - 1));
          end else if (k < 92 && cnt < MAX_SLOTS) begin
            idx = dra_pkg::SLOT_W'($urandom_range(cnt, MAX_SLOTS - 1));
          end
        end
        send_req(act, idx, t_ms);
        sender_gap();
      end
    end

    // last part, no idling: grow the table to MAX_SLOTS, then probe it while full
    drain_results();
    quiet = 1'b1;
    set_config(7'd64, 16'd0, 16'd0);
    while (live_count() < MAX_SLOTS) begin
      t_ms = t_ms + 1;
      send_req(dra_pkg::ACTION_ALLOC, dra_pkg::SLOT_W'($urandom_range(0, MAX_SLOTS - 1)),
               t_ms);
    end
    send_req(dra_pkg::ACTION_ALLOC, 10'd0, t_ms);
    send_req(dra_pkg::ACTION_FREE, 10'h3FF, t_ms);
    send_req(dra_pkg::ACTION_ALLOC, 10'd0, t_ms);
    send_req(dra_pkg::ACTION_ALLOC, 10'd0, t_ms + 1);
    send_req(dra_pkg::ACTION_FREE, 10'd30, t_ms + 1);
    send_req(dra_pkg::ACTION_ALLOC, 10'd0, t_ms + 5);
    send_req(dra_pkg::ACTION_FREE, 10'd700, t_ms + 5);
    send_req(dra_pkg::ACTION_ALLOC, 10'd0, t_ms + 9);
    drain_results();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (err_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
